// ----- rtl/core/spd_inv_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spd_inv_pkg
// Shared types, widths and saturation helpers for the SPD matrix inverse.
// ---------------------------------------------------------------------------
package spd_inv_pkg;

  localparam int IW        = 48;
  localparam int VW        = 32;
  localparam int FRAC      = 16;
  localparam int THW       = 31;
  localparam int MAX_ORDER = 8;
  localparam int IDXW      = 3;
  localparam int CELLS     = MAX_ORDER * MAX_ORDER;

  typedef logic signed [IW-1:0] ival_t;

  localparam ival_t IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam ival_t IMIN = {1'b1, {(IW-1){1'b0}}};
  localparam ival_t ONE  = ival_t'(1) <<< FRAC;

  localparam logic [1:0] CFG_MATRIX_SIZE = 2'd0;
  localparam logic [1:0] CFG_NEAR_ZERO   = 2'd1;
  localparam logic [1:0] CFG_PIVOT       = 2'd2;

  typedef enum logic {OP_DIV, OP_SQRT} ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_req_t;

  function automatic logic [IW-1:0] mag(input ival_t x);
    logic [IW-1:0] u;
    u = x;
    return x[IW-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic ival_t sat_mag(input logic neg, input logic over,
                                    input logic [IW-2:0] m);
    logic [IW-1:0] u;
    u = {1'b0, m};
    if (over) return neg ? IMIN : IMAX;
    return neg ? ival_t'(~u + 1'b1) : ival_t'(u);
  endfunction

endpackage

// ----- rtl/core/spd_inv_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spd_inv_mul
// Iterative Q32.16 multiplier: four half-width partial products, truncate
// toward zero, saturate to the internal width.
// ---------------------------------------------------------------------------
module spd_inv_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  spd_inv_pkg::ival_t  a,
  input  spd_inv_pkg::ival_t  b,
  output spd_inv_pkg::ival_t  product,
  output logic                done
);
  import spd_inv_pkg::*;

  localparam int HW = IW / 2;

  logic              busy;
  logic [2:0]        cnt;
  logic              neg;
  logic [IW-1:0]     ma, mb, pp;
  logic [1:0]        ph;
  logic [2*IW-1:0]   acc, pp_shift;
  logic [HW-1:0]     opa, opb;
  logic [2*IW-FRAC-1:0] scaled;

  always_comb begin
    opa = cnt[1] ? ma[IW-1:HW] : ma[HW-1:0];
    opb = cnt[0] ? mb[IW-1:HW] : mb[HW-1:0];
    unique case (ph)
      2'd0:       pp_shift = {{IW{1'b0}}, pp};
      2'd1, 2'd2: pp_shift = {{HW{1'b0}}, pp, {HW{1'b0}}};
      default:    pp_shift = {pp, {IW{1'b0}}};
    endcase
    scaled = acc[2*IW-1:FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= mag(a);
      mb  <= mag(b);
      neg <= a[IW-1] ^ b[IW-1];
      acc <= '0;
    end else if (busy) begin
      if (cnt <= 3'd3) begin
        pp <= opa * opb;
        ph <= cnt[1:0];
      end
      if (cnt >= 3'd1 && cnt <= 3'd4) acc <= acc + pp_shift;
      if (cnt == 3'd5)
        product <= sat_mag(neg, |scaled[2*IW-FRAC-1:IW-1], scaled[IW-2:0]);
    end
  end

endmodule

// ----- rtl/core/spd_inv_divsqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spd_inv_divsqrt
// Shared serial unit: restoring Q32.16 divide (one quotient bit per cycle)
// or integer square root of num * 2^16 (one root bit per cycle).
// ---------------------------------------------------------------------------
module spd_inv_divsqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  spd_inv_pkg::ds_req_t req,
  input  spd_inv_pkg::ival_t   num,
  input  spd_inv_pkg::ival_t   den,
  output spd_inv_pkg::ival_t   result,
  output logic                 done
);
  import spd_inv_pkg::*;

  localparam int NW  = IW + FRAC;
  localparam int RTW = NW / 2;
  localparam int SRW = RTW + 4;
  localparam int CW  = $clog2(NW) + 1;

  logic           busy;
  logic [CW-1:0]  cnt, last_cnt;
  ds_op_t         op_r;
  logic           neg, num_neg, dzero;
  logic [IW-1:0]  d;
  logic [NW-1:0]  nsh, q;
  logic [IW:0]    rem, rem_sh, rem_dv;
  logic           ge, sge;
  logic [SRW-1:0] sq_sh, trial, sq_nx;

  always_comb begin
    rem_sh   = {rem[IW-1:0], nsh[NW-1]};
    ge       = rem_sh >= {1'b0, d};
    rem_dv   = ge ? rem_sh - {1'b0, d} : rem_sh;
    sq_sh    = {rem[SRW-3:0], nsh[NW-1 -: 2]};
    trial    = {2'b00, q[RTW-1:0], 2'b01};
    sge      = sq_sh >= trial;
    sq_nx    = sge ? sq_sh - trial : sq_sh;
    last_cnt = (op_r == OP_DIV) ? CW'(NW - 1) : CW'(RTW - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt + 1'b1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r    <= req.op;
      nsh     <= {mag(num), {FRAC{1'b0}}};
      d       <= mag(den);
      neg     <= num[IW-1] ^ den[IW-1];
      num_neg <= num[IW-1];
      dzero   <= (den == '0);
      rem     <= '0;
      q       <= '0;
    end else if (busy) begin
      if (cnt <= last_cnt) begin
        if (op_r == OP_DIV) begin
          rem <= rem_dv;
          q   <= {q[NW-2:0], ge};
          nsh <= {nsh[NW-2:0], 1'b0};
        end else begin
          rem <= {{(IW+1-SRW){1'b0}}, sq_nx};
          q   <= {q[NW-2:0], sge};
          nsh <= {nsh[NW-3:0], 2'b00};
        end
      end else if (op_r == OP_DIV) begin
        result <= dzero ? sat_mag(num_neg, 1'b1, {(IW-1){1'b0}})
                        : sat_mag(neg, |q[NW-1:IW-1], q[IW-2:0]);
      end else begin
        result <= ival_t'({{(IW-RTW){1'b0}}, q[RTW-1:0]});
      end
    end
  end

endmodule

// ----- rtl/core/spd_matrix_inverse.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spd_matrix_inverse
// Inverse of a symmetric positive definite matrix, Q16.16 in and out.
// ---------------------------------------------------------------------------
// Elements load one per cycle into the input memory. The element marked last
// starts the run; the block then stalls input until the last result is in the
// output register. Orders 1 and 2 use the reciprocal and determinant forms.
// Order 3 and up factor, invert the factor and form the product, all through
// one work memory read port, one iterative multiplier (roughly n^3/1.4
// multiply-accumulate steps) and one serial divide/square-root unit (n^2
// divides and up to n roots). A singular run gives one flagged result.
// ---------------------------------------------------------------------------
module spd_matrix_inverse (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [spd_inv_pkg::THW-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spd_inv_pkg::IDXW-1:0]      row_index,
  input  logic [spd_inv_pkg::IDXW-1:0]      col_index,
  input  logic signed [spd_inv_pkg::VW-1:0] element_value,
  input  logic                              last_element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spd_inv_pkg::IDXW-1:0]      out_row,
  output logic [spd_inv_pkg::IDXW-1:0]      out_col,
  output logic signed [spd_inv_pkg::VW-1:0] inverse_value,
  output logic                              status,
  output logic                              last_result
);
  import spd_inv_pkg::*;

  localparam int CNW = IDXW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_LD0, S_LD1, S_LD2, S_LD3, S_M1W, S_M2W, S_DCHK,
    S_INIT, S_INITW, S_KCHK, S_RD1, S_RD2, S_MULW, S_FIN, S_SQW, S_DIVW,
    S_EMIT, S_NEXT, S_SING
  } state_t;

  typedef enum logic [2:0] {PH_ONE, PH_TWO, PH_CHOL, PH_GINV, PH_PROD} phase_t;

  state_t state;
  phase_t phase;

  logic [3:0]     size_r;
  logic [THW-1:0] nzt, pth;
  logic [CNW-1:0] n_r, i, j, k, kend, kstart;
  ival_t          s, opa, a00, a01, a11, p1, den;
  ival_t          piv [MAX_ORDER];

  logic signed [VW-1:0] amem [CELLS];
  ival_t                wmem [2*CELLS];
  logic [2*IDXW-1:0]    a_raddr;
  logic signed [VW-1:0] a_rdata;
  logic [2*IDXW:0]      w_raddr, w_waddr, addr1, addr2;
  ival_t                w_rdata;
  logic                 w_we;

  logic    in_accept, out_free, last_pos, s_below, s_pos;
  ival_t   a_ext, nb, num2, piv_rd, thr_p, thr_n;

  logic    mul_start, mul_done;
  ival_t   mul_a, mul_b, mul_p;
  ds_req_t ds_req;
  ival_t   ds_num, ds_den, ds_res;
  logic    ds_done;

  function automatic ival_t fadd(input ival_t x, input ival_t y);
    logic [IW:0] t;
    t = {x[IW-1], x} + {y[IW-1], y};
    if (t[IW] != t[IW-1]) return t[IW] ? IMIN : IMAX;
    return ival_t'(t[IW-1:0]);
  endfunction

  function automatic ival_t fsub(input ival_t x, input ival_t y);
    ival_t ny;
    ny = (y == IMIN) ? IMAX : -y;
    return fadd(x, ny);
  endfunction

  function automatic logic signed [VW-1:0] sat_out(input ival_t x);
    if (&x[IW-1:VW-1] || ~|x[IW-1:VW-1]) return x[VW-1:0];
    return x[IW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
  endfunction

  spd_inv_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  spd_inv_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .req    (ds_req),
    .num    (ds_num),
    .den    (ds_den),
    .result (ds_res),
    .done   (ds_done)
  );

  always_comb begin
    in_stall  = (state != S_IDLE);
    in_accept = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    last_pos  = (i == n_r - 1'b1) && (j == n_r - 1'b1);
    a_ext     = ival_t'(a_rdata);
    nb        = fsub('0, a01);
    thr_p     = ival_t'({{(IW-THW){1'b0}}, pth});
    thr_n     = ival_t'({{(IW-THW){1'b0}}, nzt});
    s_below   = s < thr_p;
    s_pos     = !s[IW-1] && (s != '0);
    piv_rd    = piv[(phase == PH_GINV) ? j[IDXW-1:0] : i[IDXW-1:0]];
    kstart    = (i > j) ? i : j;

    if (i == '0 && j == '0)       num2 = a11;
    else if (i == 1 && j == 1)    num2 = a00;
    else                          num2 = nb;

    unique case (phase)
      PH_CHOL: kend = i;
      PH_GINV: kend = j;
      default: kend = n_r;
    endcase

    unique case (phase)
      PH_CHOL: begin
        addr1 = {1'b0, i[IDXW-1:0], k[IDXW-1:0]};
        addr2 = {1'b0, j[IDXW-1:0], k[IDXW-1:0]};
      end
      PH_GINV: begin
        addr1 = {1'b0, j[IDXW-1:0], k[IDXW-1:0]};
        addr2 = {1'b1, k[IDXW-1:0], i[IDXW-1:0]};
      end
      default: begin
        addr1 = {1'b1, k[IDXW-1:0], i[IDXW-1:0]};
        addr2 = {1'b1, k[IDXW-1:0], j[IDXW-1:0]};
      end
    endcase
    w_raddr = (state == S_RD1) ? addr2 : addr1;

    if (state == S_LD0)      a_raddr = {IDXW'(0), IDXW'(0)};
    else if (state == S_LD1) a_raddr = {IDXW'(0), IDXW'(1)};
    else if (state == S_LD2) a_raddr = {IDXW'(1), IDXW'(1)};
    else                     a_raddr = {i[IDXW-1:0], j[IDXW-1:0]};

    w_we    = (state == S_DIVW) && ds_done && (phase == PH_CHOL || phase == PH_GINV);
    w_waddr = {(phase == PH_GINV), j[IDXW-1:0], i[IDXW-1:0]};

    mul_start = (state == S_RD2) || (state == S_LD3 && phase == PH_TWO) ||
                (state == S_M1W && mul_done);
    if (state == S_RD2) begin
      mul_a = opa;
      mul_b = w_rdata;
    end else if (state == S_LD3) begin
      mul_a = a00;
      mul_b = a_ext;
    end else begin
      mul_a = a01;
      mul_b = a01;
    end

    ds_req.start = 1'b0;
    ds_req.op    = OP_DIV;
    ds_num       = s;
    ds_den       = piv_rd;
    if (state == S_FIN) begin
      unique case (phase)
        PH_CHOL: begin
          if (i != j) begin
            ds_req.start = 1'b1;
          end else if (!s_below && s_pos) begin
            ds_req.start = 1'b1;
            ds_req.op    = OP_SQRT;
          end
        end
        PH_GINV: ds_req.start = 1'b1;
        PH_ONE: begin
          ds_req.start = 1'b1;
          ds_num       = ONE;
          ds_den       = den;
        end
        PH_TWO: begin
          ds_req.start = 1'b1;
          ds_num       = num2;
          ds_den       = den;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    a_rdata <= amem[a_raddr];
    if (in_accept) amem[{row_index, col_index}] <= element_value;
  end

  always_ff @(posedge clk) begin
    w_rdata <= wmem[w_raddr];
    if (w_we) wmem[w_waddr] <= ds_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_r <= 4'd8;
      nzt    <= THW'(1);
      pth    <= THW'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: size_r <= cfg_data[3:0];
        CFG_NEAR_ZERO:   nzt    <= cfg_data;
        CFG_PIVOT:       pth    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT && state != S_SING)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_accept && last_element) state <= S_START;
        S_START: begin
          i <= '0;
          j <= '0;
          n_r <= (size_r > 4'd8) ? CNW'(MAX_ORDER) : CNW'(size_r);
          if (size_r == 4'd0) begin
            state <= S_SING;
          end else if (size_r >= 4'd3) begin
            phase <= PH_CHOL;
            state <= S_INIT;
          end else begin
            phase <= (size_r == 4'd1) ? PH_ONE : PH_TWO;
            state <= S_LD0;
          end
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          a00   <= a_ext;
          state <= S_LD2;
        end
        S_LD2: begin
          a01   <= a_ext;
          state <= S_LD3;
        end
        S_LD3: begin
          a11 <= a_ext;
          if (phase == PH_TWO) begin
            state <= S_M1W;
          end else if (mag(a00) < thr_n) begin
            state <= S_SING;
          end else begin
            den   <= a00;
            state <= S_FIN;
          end
        end
        S_M1W: if (mul_done) begin
          p1    <= mul_p;
          state <= S_M2W;
        end
        S_M2W: if (mul_done) begin
          den   <= fsub(p1, mul_p);
          state <= S_DCHK;
        end
        S_DCHK: state <= (mag(den) < thr_n) ? S_SING : S_FIN;
        S_INIT: begin
          unique case (phase)
            PH_CHOL: begin
              k     <= '0;
              state <= S_INITW;
            end
            PH_GINV: begin
              k     <= i;
              s     <= (i == j) ? ONE : '0;
              state <= S_KCHK;
            end
            default: begin
              k     <= kstart;
              s     <= '0;
              state <= S_KCHK;
            end
          endcase
        end
        S_INITW: begin
          s     <= a_ext;
          state <= S_KCHK;
        end
        S_KCHK: state <= (k < kend) ? S_RD1 : S_FIN;
        S_RD1: begin
          opa   <= w_rdata;
          state <= S_RD2;
        end
        S_RD2: state <= S_MULW;
        S_MULW: if (mul_done) begin
          s     <= (phase == PH_PROD) ? fadd(s, mul_p) : fsub(s, mul_p);
          k     <= k + 1'b1;
          state <= S_KCHK;
        end
        S_FIN: begin
          unique case (phase)
            PH_CHOL: begin
              if (i != j)       state <= S_DIVW;
              else if (s_below) state <= S_SING;
              else if (s_pos)   state <= S_SQW;
              else begin
                piv[i[IDXW-1:0]] <= '0;
                state            <= S_NEXT;
              end
            end
            PH_PROD: state <= S_EMIT;
            default: state <= S_DIVW;
          endcase
        end
        S_SQW: if (ds_done) begin
          piv[i[IDXW-1:0]] <= ds_res;
          state            <= S_NEXT;
        end
        S_DIVW: if (ds_done) begin
          if (phase == PH_ONE || phase == PH_TWO) begin
            s     <= ds_res;
            state <= S_EMIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_EMIT: if (out_free) begin
          out_valid     <= 1'b1;
          out_row       <= i[IDXW-1:0];
          out_col       <= j[IDXW-1:0];
          inverse_value <= sat_out(s);
          status        <= 1'b0;
          last_result   <= last_pos;
          state         <= S_NEXT;
        end
        S_NEXT: begin
          if (phase == PH_CHOL || phase == PH_GINV) begin
            state <= S_INIT;
            if (j + 1'b1 < n_r) begin
              j <= j + 1'b1;
            end else if (i + 1'b1 < n_r) begin
              i <= i + 1'b1;
              j <= i + 1'b1;
            end else begin
              phase <= (phase == PH_CHOL) ? PH_GINV : PH_PROD;
              i     <= '0;
              j     <= '0;
            end
          end else begin
            state <= (phase == PH_PROD) ? S_INIT : S_FIN;
            if (j + 1'b1 < n_r) begin
              j <= j + 1'b1;
            end else if (i + 1'b1 < n_r) begin
              i <= i + 1'b1;
              j <= '0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SING: if (out_free) begin
          out_valid     <= 1'b1;
          out_row       <= '0;
          out_col       <= '0;
          inverse_value <= '0;
          status        <= 1'b1;
          last_result   <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_last_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_element) |=> (state != S_IDLE))
    else $error("last element did not start a run");

  a_singular_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> last_result)
    else $error("singular result not marked last");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, ds_done}))
    else $error("multiplier and divider finished together");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    w_we |-> (phase == PH_CHOL || phase == PH_GINV))
    else $error("work memory write outside factor phases");

endmodule

// ----- test/spd_matrix_inverse_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spd_matrix_inverse_test
// Loads matrices into spd_matrix_inverse under random idle and stall bursts
// and compares every inverse element against an in-bench fixed-point
// predictor (Cholesky for order 3 and up). Covers the 1x1, 2x2 and factored
// paths, singular and zero-divisor runs, order zero and orders past the maximum.
// ---------------------------------------------------------------------------
module spd_matrix_inverse_test;
  import spd_inv_pkg::*;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_SINGULAR = 1'b1;
  localparam longint QMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QMIN = -QMAX - 1;
  localparam longint QONE = 64'sd65536;
  localparam int N_RANDOM = 370;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        status;
    logic        last;
  } inv_elem_t;

  class inverse_scoreboard;
    int unsigned order_cfg = 8;
    longint      near_zero = 1;
    longint      pivot_min = 1;
    longint      a_mat[64];
    longint      l_mat[64];
    longint      g_mat[64];
    longint      pivots[8];
    inv_elem_t   expected_q[$];
    int          errors = 0;

    function logic [63:0] absu(longint x);
      return x < 0 ? -x : x;
    endfunction

    function longint sat(bit neg, logic [127:0] m);
      if (m > QMAX) return neg ? QMIN : QMAX;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function longint add_q(longint a, longint b);
      longint s;
      s = a + b;
      if (s > QMAX) return QMAX;
      if (s < QMIN) return QMIN;
      return s;
    endfunction

    function longint sub_q(longint a, longint b);
      return add_q(a, (b == QMIN) ? QMAX : -b);
    endfunction

    function longint mul_q(longint a, longint b);
      logic [127:0] p;
      p = {64'b0, absu(a)} * {64'b0, absu(b)};
      return sat((a < 0) != (b < 0), p >> 16);
    endfunction

    function longint div_q(longint a, longint b);
      logic [127:0] q;
      if (b == 0) return (a < 0) ? QMIN : QMAX;
      q = ({64'b0, absu(a)} << 16) / {64'b0, absu(b)};
      return sat((a < 0) != (b < 0), q);
    endfunction

    function longint sqrt_q(longint s);
      logic [127:0] t, r, c;
      t = {64'b0, s} << 16;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= t) r = c;
      end
      return longint'(r[63:0]);
    endfunction

    function logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void push_singular();
      inv_elem_t e;
      e = '{3'd0, 3'd0, 32'd0, STATUS_SINGULAR, 1'b1};
      expected_q.push_back(e);
    endfunction

    function void note_request(logic [2:0] r, logic [2:0] c, logic signed [31:0] v,
                               logic last);
      int n;
      longint res[64];
      longint x, det, s;
      inv_elem_t e;
      a_mat[r * 8 + c] = longint'(v);
      if (!last) return;
      n = order_cfg;
      if (n == 0) begin
        push_singular();
        return;
      end
      if (n > 8) n = 8;
      if (n == 1) begin
        x = a_mat[0];
        if (absu(x) < near_zero) begin
          push_singular();
          return;
        end
        res[0] = div_q(QONE, x);
      end else if (n == 2) begin
        det = sub_q(mul_q(a_mat[0], a_mat[9]), mul_q(a_mat[1], a_mat[1]));
        if (absu(det) < near_zero) begin
          push_singular();
          return;
        end
        res[0] = div_q(a_mat[9], det);
        res[1] = div_q(sub_q(0, a_mat[1]), det);
        res[8] = res[1];
        res[9] = div_q(a_mat[0], det);
      end else begin
        for (int i = 0; i < n; i++)
          for (int j = i; j < n; j++) begin
            s = a_mat[i * 8 + j];
            for (int k = 0; k < i; k++)
              s = sub_q(s, mul_q(l_mat[i * 8 + k], l_mat[j * 8 + k]));
            if (i == j) begin
              if (s < pivot_min) begin
                push_singular();
                return;
              end
              pivots[i] = s > 0 ? sqrt_q(s) : 0;
            end else begin
              l_mat[j * 8 + i] = div_q(s, pivots[i]);
            end
          end
        for (int i = 0; i < n; i++) begin
          g_mat[i * 8 + i] = div_q(QONE, pivots[i]);
          for (int j = i + 1; j < n; j++) begin
            s = 0;
            for (int k = i; k < j; k++)
              s = sub_q(s, mul_q(l_mat[j * 8 + k], g_mat[k * 8 + i]));
            g_mat[j * 8 + i] = div_q(s, pivots[j]);
          end
        end
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            s = 0;
            for (int k = (i > j ? i : j); k < n; k++)
              s = add_q(s, mul_q(g_mat[k * 8 + i], g_mat[k * 8 + j]));
            res[i * 8 + j] = s;
          end
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          e = '{i[2:0], j[2:0], clip32(res[i * 8 + j]), STATUS_OK,
                (i == n - 1 && j == n - 1)};
          expected_q.push_back(e);
        end
    endfunction

    function void check_result(logic [2:0] r, logic [2:0] c, logic [31:0] v,
                               logic st, logic last);
      inv_elem_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result row %0d col %0d value %h", r, c, v);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r !== e.row) begin
        $error("out_row: expected %0d, got %0d", e.row, r);
        errors++;
      end
      if (c !== e.col) begin
        $error("out_col: expected %0d, got %0d", e.col, c);
        errors++;
      end
      if (v !== e.value) begin
        $error("inverse_value: expected %h, got %h", e.value, v);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_result: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [THW-1:0]    cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        row_index = '0;
  logic [2:0]        col_index = '0;
  logic signed [31:0] element_value = '0;
  logic              last_element = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_row;
  logic [2:0]        out_col;
  logic signed [31:0] inverse_value;
  logic              status;
  logic              last_result;

  inverse_scoreboard sb = new();
  int  requests_sent = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  spd_matrix_inverse DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_result(out_row, out_col, inverse_value, status, last_result);

  task automatic send_request(logic [2:0] r, logic [2:0] c, logic [31:0] v, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    row_index     <= r;
    col_index     <= c;
    element_value <= v;
    last_element  <= last;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r, c, v, last);
    requests_sent++;
    if (requests_sent > N_RANDOM - 60) quiet = 1'b1;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_config(int unsigned order, int unsigned nz, int unsigned pv);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_MATRIX_SIZE;
    cfg_data  <= THW'(order);
    @(negedge clk);
    cfg_index <= CFG_NEAR_ZERO;
    cfg_data  <= THW'(nz);
    @(negedge clk);
    cfg_index <= CFG_PIVOT;
    cfg_data  <= THW'(pv);
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.order_cfg = order & 4'hF;
    sb.near_zero = nz & 32'h7FFF_FFFF;
    sb.pivot_min = pv & 32'h7FFF_FFFF;
  endtask

  // row-major load of the active order; order zero sends a lone marker
  task automatic load_matrix(logic [31:0] m[64]);
    int n;
    n = sb.order_cfg > 8 ? 8 : sb.order_cfg;
    if (n == 0) begin
      send_request(3'($urandom()), 3'($urandom()), $urandom(), 1'b1);
      return;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        send_request(3'(i), 3'(j), m[i * 8 + j], (i == n - 1 && j == n - 1));
  endtask

  task automatic random_matrix(bit broken);
    logic [31:0] m[64];
    int n, offmax;
    n = sb.order_cfg > 8 ? 8 : sb.order_cfg;
    offmax = $urandom_range(1, 32'h40000);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        if (j < i) m[i * 8 + j] = $urandom();
        else if (broken && $urandom_range(0, 1)) m[i * 8 + j] = $urandom();
        else if (i == j && broken) m[i * 8 + j] = $urandom_range(0, 32'h200000) - 32'h100000;
        else if (i == j) m[i * 8 + j] = n * offmax + $urandom_range(32'h100, 32'h80000);
        else m[i * 8 + j] = $urandom_range(0, 2 * offmax) - offmax;
      end
    if (n == 1 && !broken && $urandom_range(0, 1)) m[0] = -m[0];
    load_matrix(m);
  endtask

  initial begin
    logic [31:0] m[64];
    int order, nz, pv, runs;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(1, 1, 1);
    foreach (m[i]) m[i] = 32'h0;
    m[0] = 32'h0001_0000; load_matrix(m);
    m[0] = 32'h7FFF_FFFF; load_matrix(m);
    m[0] = 32'h8000_0000; load_matrix(m);
    m[0] = 32'hFFFF_0000; load_matrix(m);
    m[0] = 32'h0;         load_matrix(m);
    set_config(1, 0, 0);
    load_matrix(m);
    set_config(2, 32'h100, 1);
    m[0] = 32'h2_0000; m[1] = 32'h1_0000; m[8] = 32'h1_0000; m[9] = 32'h2_0000;
    load_matrix(m);
    m[0] = 32'h1_0000; m[9] = 32'h1_0000;
    load_matrix(m);
    set_config(0, 1, 1);
    load_matrix(m);
    set_config(3, 0, 0);
    foreach (m[i]) m[i] = 32'h0;
    m[1] = 32'h1_0000; m[9] = 32'h3_0000; m[18] = 32'h2_0000; m[2] = 32'hFFFF_8000;
    load_matrix(m);

    while (requests_sent < N_RANDOM) begin
      case ($urandom_range(0, 19))
        0:       order = 0;
        1,2,3,4,5: order = 1;
        6,7,8,9: order = 2;
        10,11,12,13,19: order = 3;
        14,15:   order = 4;
        16:      order = $urandom_range(5, 7);
        17:      order = 8;
        default: order = $urandom_range(9, 15);
      endcase
      case ($urandom_range(0, 7))
        0:       nz = 0;
        1:       nz = 32'h7FFF_FFFF;
        default: nz = $urandom_range(0, 32'h400);
      endcase
      case ($urandom_range(0, 9))
        0:       pv = 0;
        1:       pv = 32'h7FFF_FFFF;
        default: pv = $urandom_range(0, 32'h400);
      endcase
      set_config(order, nz, pv);
      runs = (order >= 5) ? 1 : $urandom_range(1, 4);
      repeat (runs) random_matrix($urandom_range(0, 6) == 0);
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- spd_matrix_inverse.f -----
rtl/core/spd_inv_pkg.sv
rtl/core/spd_inv_mul.sv
rtl/core/spd_inv_divsqrt.sv
rtl/core/spd_matrix_inverse.sv
test/spd_matrix_inverse_test.sv
